/* design/c3rdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package c3rdc_pkg;
    localparam int unsigned PIX_MAX   = 255;
    localparam int unsigned SUM_W     = 20;
    localparam int unsigned QUO_W     = 20;
    localparam int unsigned MAX_H     = 4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_K_TOP    = 3'd0,
        REG_K_MID    = 3'd1,
        REG_K_BOT    = 3'd2,
        REG_DIVISOR  = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } t_reg_idx;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // take input pixel, read line stores
        logic mac;        // accumulate one kernel row (or finish window update)
        logic div_start;  // load the divider
        logic div_step;   // one restoring step per channel
        logic emit_load;  // load output register
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic produces;   // current pixel is interior
        logic mac_done;
        logic div_done;
    } t_stat;

    function automatic logic signed [8:0] weight_of(input logic [23:0] row, input logic [1:0] k);
        logic [7:0] b;
        b = row[8*k +: 8];
        return {b[7], b};
    endfunction
endpackage
`default_nettype wire

/* design/c3rdc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module c3rdc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/c3rdc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module c3rdc_ctrl
    import c3rdc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    input  wire logic  i_out_valid,
    output      logic  o_stall,
    output      t_cmd  o_cmd
);
    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.mac = 1'b1;
                if (i_stat.mac_done) begin
                    if (i_stat.produces) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_valid || !i_out_stall) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("accepting while busy");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_load |-> (!i_out_valid || !i_out_stall))
        else $error("output overwritten");
    a_div_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == ST_DIV))
        else $error("divider start lost");
`endif
endmodule
`default_nettype wire

/* design/c3rdc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module c3rdc_dp
    import c3rdc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output      t_stat       o_stat,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_out_stall,
    output      logic        o_valid,
    output      logic [7:0]  o_red,
    output      logic [7:0]  o_green,
    output      logic [7:0]  o_blue,
    output      logic [11:0] o_row,
    output      logic [9:0]  o_col,
    output      logic        o_last
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [23:0] r_k [3];
    logic [9:0]  r_div;
    logic [10:0] r_width;
    logic [12:0] r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k[0] <= 24'd0; r_k[1] <= 24'd256; r_k[2] <= 24'd0;
            r_div <= 10'd1; r_width <= 11'd1024; r_height <= 13'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_K_TOP:   r_k[0]   <= i_cfg_data;
                REG_K_MID:   r_k[1]   <= i_cfg_data;
                REG_K_BOT:   r_k[2]   <= i_cfg_data;
                REG_DIVISOR: r_div    <= i_cfg_data[9:0];
                REG_WIDTH:   r_width  <= i_cfg_data[10:0];
                REG_HEIGHT:  r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [CW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [9:0]    d_eff;
    always_comb begin
        if (r_width < 11'd3) w_eff = CW'(3);
        else if ({21'd0, r_width} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(r_width);
        if (r_height < 13'd3) h_eff = 13'd3;
        else if (r_height > 13'(MAX_H)) h_eff = 13'(MAX_H);
        else h_eff = r_height;
        d_eff = (r_div == 10'd0) ? 10'd1 : r_div;
    end

    // counters and captured pixel
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic [23:0]   r_px;
    logic [AW-1:0] col_a;
    assign col_a = r_col[AW-1:0];
    logic [23:0] old_px, new_px;

    c3rdc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk(i_clk), .i_we(i_cmd.mac && o_stat.mac_done), .i_waddr(col_a),
        .i_wdata(new_px), .i_raddr(col_a), .o_rdata(old_px));
    c3rdc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk(i_clk), .i_we(i_cmd.mac && o_stat.mac_done), .i_waddr(col_a),
        .i_wdata(r_px), .i_raddr(col_a), .o_rdata(new_px));

    // window: columns c-2, c-1, rows 0..2
    logic [23:0] r_win [6];
    logic [1:0]  r_kr;
    logic signed [SUM_W-1:0] r_acc [3];
    logic [23:0] nb [3][3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nb[i][0] = r_win[i];
            nb[i][1] = r_win[3+i];
        end
        nb[0][2] = old_px;
        nb[1][2] = new_px;
        nb[2][2] = r_px;
    end

    logic produces;
    assign produces = (r_row >= 12'd2) && (r_col >= CW'(2));
    assign o_stat.produces = produces;
    assign o_stat.mac_done = (r_kr == 2'd2);

    // one kernel row per cycle, three taps per channel
    logic signed [SUM_W-1:0] row_sum [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            row_sum[ch] = '0;
            for (int j = 0; j < 3; j++) begin
                row_sum[ch] = row_sum[ch] + SUM_W'(
                    $signed({1'b0, nb[r_kr][j][8*ch +: 8]}) * weight_of(r_k[r_kr], 2'(j)));
            end
        end
    end

    logic last_col, last_row;
    assign last_col = ({{(32-CW){1'b0}}, r_col} + 32'd1) >= {{(32-CW){1'b0}}, w_eff};
    assign last_row = ({20'd0, r_row} + 32'd1) >= {19'd0, h_eff};

    // result tags, held until emission
    logic [11:0] r_orow;
    logic [9:0]  r_ocol;
    logic        r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_kr  <= '0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_px <= {i_blue, i_green, i_red};
                r_kr <= '0;
                for (int ch = 0; ch < 3; ch++) r_acc[ch] <= '0;
            end
            if (i_cmd.mac) begin
                for (int ch = 0; ch < 3; ch++) r_acc[ch] <= r_acc[ch] + row_sum[ch];
                r_kr <= (r_kr == 2'd2) ? 2'd0 : r_kr + 2'd1;
                if (r_kr == 2'd2) begin
                    // advance window and counters
                    r_orow  <= r_row - 12'd1;
                    r_ocol  <= 10'(r_col - CW'(1));
                    r_olast <= last_col && last_row;
                    r_win[0] <= r_win[3]; r_win[1] <= r_win[4]; r_win[2] <= r_win[5];
                    r_win[3] <= old_px;   r_win[4] <= new_px;   r_win[5] <= r_px;
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= last_row ? 12'd0 : r_row + 12'd1;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
        end
    end

    // restoring divider on magnitudes, one bit per cycle, three channels
    logic [QUO_W-1:0] r_rem [3];
    logic [QUO_W-1:0] r_quo [3];
    logic             r_neg [3];
    logic [4:0]       r_dcnt;
    logic [QUO_W-1:0] acc_full [3];
    assign o_stat.div_done = (r_dcnt == 5'(QUO_W - 1));
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            // final row sum joins here
            acc_full[ch] = QUO_W'(r_acc[ch] + row_sum[ch]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dcnt <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_neg[ch] <= acc_full[ch][QUO_W-1];
                r_quo[ch] <= acc_full[ch][QUO_W-1] ? -acc_full[ch] : acc_full[ch];
                r_rem[ch] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 5'd1;
            for (int ch = 0; ch < 3; ch++) begin
                logic [QUO_W:0] trial;
                trial = {r_rem[ch][QUO_W-1:0], r_quo[ch][QUO_W-1]} - {11'd0, d_eff};
                if (!trial[QUO_W]) begin
                    r_rem[ch] <= trial[QUO_W-1:0];
                    r_quo[ch] <= {r_quo[ch][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= {r_rem[ch][QUO_W-2:0], r_quo[ch][QUO_W-1]};
                    r_quo[ch] <= {r_quo[ch][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // clamp
    logic [7:0] clamped [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (r_neg[ch] || r_quo[ch] == '0) clamped[ch] = 8'd0;
            else if (r_quo[ch] > QUO_W'(PIX_MAX)) clamped[ch] = 8'(PIX_MAX);
            else clamped[ch] = r_quo[ch][7:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_valid <= 1'b0;
        end
        if (i_cmd.emit_load) begin
            o_red <= clamped[0]; o_green <= clamped[1]; o_blue <= clamped[2];
            o_row <= r_orow; o_col <= r_ocol; o_last <= r_olast;
        end
    end

`ifndef SYNTH
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH))
        else $error("column counter out of range");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_stall) |=> $stable(o_red) && o_valid)
        else $error("stalled result changed");
    a_kr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kr != 2'd3)
        else $error("kernel row index out of range");
`endif
endmodule
`default_nettype wire

/* design/conv3x3_rgb_divide_clamp.sv */
`timescale 1ns / 1ps
`default_nettype none
// After the input transfer the three kernel rows are accumulated; interior pixels then run the
// bit-serial divider and load once the output is free. Input is stalled until a pixel is done.
// Line stores are read at capture and written at the end of the row accumulation.
// Reset: synchronous, active low; clears counters, window, state, o_valid; config to defaults.
// Line stores are not cleared and need no clearing pass.
module conv3x3_rgb_divide_clamp
    import c3rdc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [7:0]  o_red_out,
    output      logic [7:0]  o_green_out,
    output      logic [7:0]  o_blue_out,
    output      logic [11:0] o_out_row,
    output      logic [9:0]  o_out_col,
    output      logic        o_frame_last
);
    t_cmd  cmd;
    t_stat stat;

    c3rdc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_stat(stat), .i_out_valid(o_valid), .o_stall(o_stall), .o_cmd(cmd));

    c3rdc_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_red(i_red_in), .i_green(i_green_in), .i_blue(i_blue_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_out_stall(i_stall), .o_valid(o_valid),
        .o_red(o_red_out), .o_green(o_green_out), .o_blue(o_blue_out),
        .o_row(o_out_row), .o_col(o_out_col), .o_last(o_frame_last));
endmodule
`default_nettype wire
